// ===== src/wfl_pkg.sv =====
package wfl_pkg;

    // Configuration register indexes on the write channel.
    localparam logic [2:0] REG_FLOOD_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_WINDOW_TICKS    = 3'd1;
    localparam logic [2:0] REG_FLOOD_ACTION    = 3'd2;
    localparam logic [2:0] REG_WARNING_LIMIT   = 3'd3;
    localparam logic [2:0] REG_WARNING_PENALTY = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [14:0] FLOOD_THRESHOLD_RST = 15'd5;
    localparam logic [31:0] WINDOW_TICKS_RST    = 32'd60;
    localparam logic [2:0]  FLOOD_ACTION_RST    = 3'd1;
    localparam logic [14:0] WARNING_LIMIT_RST   = 15'd3;
    localparam logic [1:0]  WARNING_PENALTY_RST = 2'd0;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Actions taken when the flood threshold is met inside the window.
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_WARN       = 3'd1,
        ACT_COUNTED    = 3'd2,
        ACT_DISCONNECT = 3'd3,
        ACT_KICK       = 3'd4,
        ACT_TEMP_BAN   = 3'd5,
        ACT_BAN        = 3'd6
    } wfl_action_t;

    // Verdict codes on the result channel.
    localparam logic [2:0] VERDICT_NONE       = 3'd0;
    localparam logic [2:0] VERDICT_WARNING    = 3'd1;
    localparam logic [2:0] VERDICT_DISCONNECT = 3'd2;
    localparam logic [2:0] VERDICT_KICK       = 3'd3;
    localparam logic [2:0] VERDICT_TEMP_BAN   = 3'd4;
    localparam logic [2:0] VERDICT_BAN        = 3'd5;

    // Live configuration as seen by the back part.
    typedef struct packed {
        logic [14:0] flood_threshold;
        logic [31:0] window_ticks;
        logic [2:0]  flood_action;
        logic [14:0] warning_limit;
        logic [1:0]  warning_penalty;
    } wfl_cfg_t;

    // Head of the event queue.
    typedef struct packed {
        logic        valid;
        logic [63:0] tick;
    } wfl_item_t;

endpackage

// ===== src/windowed_flood_limiter_core.sv =====
// Windowed flood limiter for one sender.
// Events arrive on the s_ stream, one tick value per transfer in s_tdata.
// Every event yields exactly one result on the m_ stream: blocked in bit 0,
// the verdict in bits 3:1 and user_closed in bit 4.
// Configuration is written through cfg_valid/cfg_index/cfg_data while the
// block is idle; this binds the user, the block itself does not enforce it.
// cfg_ready is always high; each write is registered in the configuration.
// An event is stored in the queue, then its decision in the result register.
// Throughput: one event per cycle while m_tready is high, limited by the back
// part's combinational window compare and counter update for the next event.
// A two-entry queue separates the input from the decision logic, and the
// result register holds its transfer while m_tready is low; the input keeps
// accepting until the queue is full, then s_tready drops.
// Reset (aresetn low, synchronous) empties the queue and the result register,
// clears the event count, window start and warning total, and restores the
// configuration defaults: threshold 5, window 60 ticks, action warn,
// warning limit 3, penalty disconnect.
module windowed_flood_limiter_core
    import wfl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] current_tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] blocked, [3:1] verdict, [4] user_closed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    wfl_cfg_t  cfg_reg;
    wfl_item_t head;
    logic      pop;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flood_threshold <= FLOOD_THRESHOLD_RST;
            cfg_reg.window_ticks    <= WINDOW_TICKS_RST;
            cfg_reg.flood_action    <= FLOOD_ACTION_RST;
            cfg_reg.warning_limit   <= WARNING_LIMIT_RST;
            cfg_reg.warning_penalty <= WARNING_PENALTY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FLOOD_THRESHOLD: cfg_reg.flood_threshold <= cfg_data[14:0];
                REG_WINDOW_TICKS:    cfg_reg.window_ticks    <= cfg_data;
                REG_FLOOD_ACTION:    cfg_reg.flood_action    <= cfg_data[2:0];
                REG_WARNING_LIMIT:   cfg_reg.warning_limit   <= cfg_data[14:0];
                REG_WARNING_PENALTY: cfg_reg.warning_penalty <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    wfl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    wfl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/wfl_front.sv =====
module wfl_front
    import wfl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] current_tick
    output wfl_item_t   head,
    input  logic        pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [63:0]      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push;
    logic             take;

    // The queue takes a transfer whenever it has a free entry.
    assign s_tready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign take     = pop && head.valid;

    assign head.valid = (fill_reg != '0);
    assign head.tick  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping; the pointers wrap at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !take) begin
            fill_next = fill_reg + 1'b1;
        end else if (take && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Event payload storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_tdata;
        end
    end

endmodule

// ===== src/wfl_back.sv =====
module wfl_back
    import wfl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  wfl_cfg_t   cfg,
    input  wfl_item_t  head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata   // [0] blocked, [3:1] verdict, [4] user_closed, [7:5] zero
);

    logic [15:0] event_count_reg, event_count_next;
    logic [63:0] window_start_reg, window_start_next;
    logic [15:0] warning_total_reg, warning_total_next;
    logic        m_valid_reg;
    logic [4:0]  result_reg;

    logic        take;
    logic [63:0] window_end;
    logic        live;
    logic [15:0] thr16;
    logic [16:0] thr2;
    logic [15:0] count_inc;
    logic [15:0] warn_inc;
    logic        escalate;
    logic [2:0]  warn_verdict;
    logic        blocked;
    logic [2:0]  verdict;
    logic        closed;

    // An event leaves the queue when the output register is free or drains now.
    assign take = head.valid && (!m_valid_reg || m_tready);
    assign pop  = take;

    // Window test, threshold compares and the saturating warning step.
    always_comb begin
        window_end   = window_start_reg + {32'd0, cfg.window_ticks};
        live         = window_end > head.tick;
        thr16        = {1'b0, cfg.flood_threshold};
        thr2         = {thr16, 1'b0};
        count_inc    = event_count_reg + 16'd1;
        warn_inc     = (warning_total_reg == 16'hFFFF) ? warning_total_reg
                                                       : warning_total_reg + 16'd1;
        escalate     = warn_inc >= {1'b0, cfg.warning_limit};
        warn_verdict = escalate ? (VERDICT_DISCONNECT + {1'b0, cfg.warning_penalty})
                                : VERDICT_WARNING;
    end

    // Per-event decision and state update.
    always_comb begin
        event_count_next   = event_count_reg;
        window_start_next  = window_start_reg;
        warning_total_next = warning_total_reg;
        blocked            = 1'b0;
        verdict            = VERDICT_NONE;
        closed             = 1'b0;

        if (event_count_reg == 16'd0) begin
            // First event opens a window.
            window_start_next = head.tick;
            event_count_next  = 16'd1;
        end else if (event_count_reg == thr16 && live) begin
            // Threshold met inside the window: the configured action fires.
            blocked = 1'b1;
            case (wfl_action_t'(cfg.flood_action))
                ACT_WARN: begin
                    verdict          = VERDICT_WARNING;
                    event_count_next = count_inc;
                end
                ACT_COUNTED: begin
                    warning_total_next = warn_inc;
                    verdict            = warn_verdict;
                    closed             = escalate;
                    if (!escalate) begin
                        event_count_next = count_inc;
                    end
                end
                ACT_DISCONNECT, ACT_KICK, ACT_TEMP_BAN, ACT_BAN: begin
                    verdict = cfg.flood_action - 3'd1;
                    closed  = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (event_count_reg > thr16 && live) begin
            // Past threshold: blocked; counted mode warns per further threshold's worth.
            blocked = 1'b1;
            if (wfl_action_t'(cfg.flood_action) == ACT_COUNTED &&
                {1'b0, event_count_reg} == thr2) begin
                warning_total_next = warn_inc;
                verdict            = warn_verdict;
                closed             = escalate;
                if (!escalate) begin
                    event_count_next = event_count_reg - thr16 + 16'd1;
                end
            end else begin
                event_count_next = count_inc;
            end
        end else if (!live) begin
            // Expired window restarts at this event.
            window_start_next = head.tick;
            event_count_next  = 16'd1;
        end else begin
            event_count_next = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_count_reg   <= '0;
            window_start_reg  <= '0;
            warning_total_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (take) begin
                event_count_reg   <= event_count_next;
                window_start_reg  <= window_start_next;
                warning_total_reg <= warning_total_next;
                m_valid_reg       <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= {closed, verdict, blocked};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, result_reg};

endmodule

// ===== src/wfl_checker.sv =====
module wfl_checker
    import wfl_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A stalled result keeps its transfer pending and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // Any verdict comes with a blocked event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:1] != VERDICT_NONE) |-> m_tdata[0])
        else $error("verdict on a passed event");

    // Closing the sender only comes with a penalty verdict.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |->
            (m_tdata[3:1] >= VERDICT_DISCONNECT) && (m_tdata[3:1] <= VERDICT_BAN))
        else $error("close without penalty verdict");

endmodule

bind windowed_flood_limiter_core wfl_checker u_wfl_checker (.*);
